FILE: sv/lwma_pkg.sv
// ----------------------------------------------------------------------------
// lwma_pkg: shared constants and types
// Window size, derived widths and the record layout for the difficulty block.
// ----------------------------------------------------------------------------
package lwma_pkg;

  localparam int WINDOW = 60;
  localparam int DEPTH = WINDOW + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int SEEN_W = $clog2(DEPTH + 1);
  localparam int N_W = $clog2(WINDOW + 1);
  localparam int MIN_RECORDS = 3;

  localparam int TGT_W = 16;
  localparam int CLAMP_FACTOR = 6;
  localparam int CLAMP_W = $clog2(CLAMP_FACTOR * (2 ** TGT_W - 1) + 1);

  localparam int NN_W = $clog2(WINDOW * (WINDOW + 1) + 1);
  localparam int MULT_W = TGT_W + NN_W;
  localparam int WORK_W = 128;
  localparam int NUM_W = WORK_W + MULT_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam longint unsigned MAX_WSUM =
    longint'(CLAMP_FACTOR * (2 ** TGT_W - 1)) * longint'(WINDOW) * longint'(WINDOW + 1) / 2;
  localparam int WSUM_W = $clog2(MAX_WSUM + 1);

  // one stored block record
  typedef struct packed {
    logic [63:0] ts;
    logic [63:0] work_high;
    logic [63:0] work_low;
  } rec_t;

  // divider status back to the controller
  typedef struct packed {
    logic done;
    logic ovf;
  } div_status_t;

endpackage

FILE: sv/lwma_ram.sv
// ----------------------------------------------------------------------------
// lwma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lwma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lwma_divider.sv
// ----------------------------------------------------------------------------
// lwma_divider: bit-serial multiply then restoring divide
// Forms diff * mult one multiplier bit a cycle, drops the low bit, then
// divides by the weighted sum one quotient bit a cycle.
// ----------------------------------------------------------------------------
module lwma_divider import lwma_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WORK_W-1:0]  diff,
  input  logic [MULT_W-1:0]  mult,
  input  logic [WSUM_W-1:0]  divisor,
  output logic [WORK_W-1:0]  quotient,
  output div_status_t        status
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]        phase;
  logic [CNT_W-1:0]  cnt;
  logic [WORK_W-1:0] diff_r;
  logic [MULT_W-1:0] mult_r;
  logic [WSUM_W-1:0] dvs;
  logic [NUM_W-1:0]  acc;
  logic [WSUM_W-1:0] rem;
  logic [WORK_W-1:0] q;
  logic              ovf;
  logic              done;

  logic [NUM_W-1:0]  mul_next;
  logic [WSUM_W:0]   shifted;
  logic              qbit;
  logic [WSUM_W:0]   sub;

  // one multiply step and one divide step
  always_comb begin
    mul_next = {acc[NUM_W-2:0], 1'b0} +
               (mult_r[MULT_W-1] ? NUM_W'(diff_r) : '0);
    shifted = {rem, acc[NUM_W-1]};
    qbit = (shifted >= {1'b0, dvs});
    sub = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done <= 1'b0;
    end else begin
      // finished after the last multiply step with a zero divisor, or the last divide step
      done <= ((phase == PH_MUL) && (cnt == CNT_W'(1)) && (dvs == '0)) ||
              ((phase == PH_DIV) && (cnt == CNT_W'(1)));
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            diff_r <= diff;
            mult_r <= mult;
            dvs <= divisor;
            acc <= '0;
            rem <= '0;
            q <= '0;
            ovf <= 1'b0;
            cnt <= CNT_W'(MULT_W);
            phase <= PH_MUL;
          end
        end
        PH_MUL: begin
          acc <= mul_next;
          mult_r <= {mult_r[MULT_W-2:0], 1'b0};
          if (cnt == CNT_W'(1)) begin
            // zero divisor gives a zero quotient
            if (dvs == '0) begin
              phase <= PH_IDLE;
            end else begin
              cnt <= CNT_W'(NUM_W - 1);
              phase <= PH_DIV;
            end
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        PH_DIV: begin
          acc <= {acc[NUM_W-2:0], 1'b0};
          if (qbit) begin
            rem <= sub[WSUM_W-1:0];
          end else begin
            rem <= shifted[WSUM_W-1:0];
          end
          q <= {q[WORK_W-2:0], qbit};
          ovf <= ovf | q[WORK_W-1];
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  assign quotient = q;
  assign status.done = done;
  assign status.ovf = ovf;

endmodule

FILE: sv/lwma_difficulty_adjust.sv
// Records are taken one per cycle while idle; a record not marked last leaves the block idle.
// A last record starts the result: a scan of the window (one RAM read port), setup in S_PREP and
// S_START, the multiply, the divide (skipped for a zero weighted sum) and the handoff through
// S_FINISH to out_valid; no record is taken meanwhile.
// Short or out-of-order sequences return 1; a held result delays the next.
// Synchronous reset clears the sequence state and out_valid, and sets target to 120.
// ----------------------------------------------------------------------------
// lwma_difficulty_adjust: weighted moving average difficulty
// Keeps the recent block records in a RAM and computes the next difficulty
// at the last record of a sequence.
// ----------------------------------------------------------------------------
module lwma_difficulty_adjust import lwma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TGT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       timestamp,
  input  logic [63:0]       cum_diff_low,
  input  logic [63:0]       cum_diff_high,
  input  logic              last_record,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       difficulty_low,
  output logic [63:0]       difficulty_high
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]         state;
  logic [TGT_W-1:0]   target;
  logic [PTR_W-1:0]   ptr;
  logic [SEEN_W-1:0]  seen;
  logic               fault;
  logic [63:0]        prev_ts;
  logic               use_one;

  logic [N_W-1:0]     n_reg;
  logic [PTR_W-1:0]   scan_addr;
  logic [SEEN_W-1:0]  issue_cnt;
  logic               rd_valid;
  logic [N_W-1:0]     rd_k;
  logic [63:0]        prev_t;
  logic [WORK_W-1:0]  start_work;
  logic [WSUM_W-1:0]  wsum;
  logic [WORK_W-1:0]  diff;
  logic [NN_W-1:0]    nn1;
  logic [MULT_W-1:0]  mult;

  logic               in_fire;
  logic [SEEN_W-1:0]  seen_next;
  logic               fault_next;
  logic [N_W-1:0]     n_acc;
  logic [PTR_W:0]     start_wide;
  logic [PTR_W-1:0]   start_acc;
  logic               issue;
  rec_t               wr_rec;
  rec_t               rd_rec;
  logic [CLAMP_W-1:0] max_st;
  logic [63:0]        delta;
  logic [63:0]        s_raw;
  logic [CLAMP_W-1:0] s_clamp;
  logic [WORK_W-1:0]  rd_work;
  logic [WORK_W-1:0]  q;
  div_status_t        div_st;

  assign in_ready = (state == S_IDLE);
  assign in_fire = in_valid & in_ready;

  // sequence bookkeeping for an incoming record
  always_comb begin
    seen_next = (seen == SEEN_W'(DEPTH)) ? seen : seen + 1'b1;
    fault_next = fault | ((seen != '0) && (timestamp < prev_ts));
    n_acc = N_W'(seen_next - 1'b1);
    if ({1'b0, ptr} >= (PTR_W + 1)'(n_acc)) begin
      start_wide = {1'b0, ptr} - (PTR_W + 1)'(n_acc);
    end else begin
      start_wide = {1'b0, ptr} + (PTR_W + 1)'(DEPTH) - (PTR_W + 1)'(n_acc);
    end
    start_acc = start_wide[PTR_W-1:0];
  end

  assign wr_rec.ts = timestamp;
  assign wr_rec.work_high = cum_diff_high;
  assign wr_rec.work_low = cum_diff_low;
  assign issue = (state == S_SCAN) && (issue_cnt <= SEEN_W'(n_reg));

  lwma_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_fire),
    .waddr (ptr),
    .wdata (wr_rec),
    .re    (issue),
    .raddr (scan_addr),
    .rdata (rd_rec)
  );

  // clamped solve time of the record being read back
  always_comb begin
    max_st = CLAMP_W'(target) * CLAMP_W'(CLAMP_FACTOR);
    delta = rd_rec.ts - prev_t;
    s_raw = (delta[63] || (delta == '0)) ? 64'd1 : delta;
    s_clamp = (s_raw > 64'(max_st)) ? max_st : s_raw[CLAMP_W-1:0];
    rd_work = {rd_rec.work_high, rd_rec.work_low};
  end

  lwma_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .diff     (diff),
    .mult     (mult),
    .divisor  (wsum),
    .quotient (q),
    .status   (div_st)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TGT_W'(120);
    end else if (cfg_we) begin
      target <= cfg_wdata;
    end
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr <= '0;
      seen <= '0;
      fault <= 1'b0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_valid <= issue;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            prev_ts <= timestamp;
            if (last_record) begin
              ptr <= '0;
              seen <= '0;
              fault <= 1'b0;
              n_reg <= n_acc;
              scan_addr <= start_acc;
              issue_cnt <= '0;
              wsum <= '0;
              if (fault_next || (seen_next < SEEN_W'(MIN_RECORDS))) begin
                use_one <= 1'b1;
                state <= S_FINISH;
              end else begin
                use_one <= 1'b0;
                state <= S_SCAN;
              end
            end else begin
              ptr <= (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
              seen <= seen_next;
              fault <= fault_next;
            end
          end
        end
        S_SCAN: begin
          nn1 <= NN_W'(((2 * N_W + 2)'(n_reg)) * ((2 * N_W + 2)'(n_reg) + 1'b1));
          if (issue) begin
            scan_addr <= (scan_addr == PTR_W'(DEPTH - 1)) ? '0 : scan_addr + 1'b1;
            issue_cnt <= issue_cnt + 1'b1;
            rd_k <= issue_cnt[N_W-1:0];
          end
          if (rd_valid) begin
            prev_t <= rd_rec.ts;
            if (rd_k == '0) begin
              start_work <= rd_work;
            end else begin
              wsum <= wsum + WSUM_W'(s_clamp) * WSUM_W'(rd_k);
            end
            if (rd_k == n_reg) begin
              diff <= rd_work - start_work;
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          mult <= MULT_W'(nn1) * MULT_W'(target);
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register, loaded on the finishing transfer
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && !out_valid) begin
      priority if (use_one || (!div_st.ovf && (q == '0))) begin
        difficulty_low <= 64'd1;
        difficulty_high <= '0;
      end else if (div_st.ovf) begin
        difficulty_low <= '1;
        difficulty_high <= '1;
      end else begin
        difficulty_low <= q[63:0];
        difficulty_high <= q[127:64];
      end
    end
  end

endmodule
